// File: rtl/rtcsci_pkg.sv
// types, constants and bcd helpers for the rtc serial command interface
// used by rtcsci_read_mux.sv and rtc_serial_command_interface.sv
// no dependencies
package rtcsci_pkg;

	localparam int unsigned CMD_BITS      = 8;
	localparam int unsigned BIT_COUNT_W   = 7;
	localparam logic [BIT_COUNT_W-1:0] BIT_COUNT_MAX = 7'd64;

	// register selector, command bits 6:4
	typedef enum logic [2:0] {
		SEL_STATUS_ONE = 3'h0,
		SEL_STATUS_TWO = 3'h4,
		SEL_DATETIME   = 3'h2,
		SEL_TIME       = 3'h6
	} reg_sel_t;

	localparam int unsigned HOUR_MODE_BIT = 1;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [2:0] weekday;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} calendar_t;

	// control from the sequencer to the read mux
	typedef struct packed {
		logic [2:0] sel;
		logic [3:0] byte_no;
		logic       hour_24;
	} read_ctl_t;

	// tens by reciprocal multiply, exact for values below 128
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  tens_x10;
		logic [6:0]  ones;
		prod     = 15'(v) * 15'd205;
		tens     = prod[14:11];
		tens_x10 = 7'(tens) * 7'd10;
		ones     = v - tens_x10;
		return {tens, ones[3:0]};
	endfunction

	function automatic logic [4:0] hour_mod12(input logic [4:0] h);
		logic [4:0] r;
		if (h >= 5'd24) begin
			r = h - 5'd24;
		end else if (h >= 5'd12) begin
			r = h - 5'd12;
		end else begin
			r = h;
		end
		return r;
	endfunction

endpackage

// File: rtl/rtcsci_if.sv
// valid/ready channel interfaces for the rtc serial command interface
// no dependencies
interface rtcsci_cmd_if;
	logic                   valid;
	logic                   ready;
	logic                   select_line;
	logic                   clock_line;
	logic                   direction_write;
	logic                   data_bit;
	logic [6:0]             time_year;
	logic [3:0]             time_month;
	logic [4:0]             time_day;
	logic [2:0]             time_weekday;
	logic [4:0]             time_hour;
	logic [5:0]             time_minute;
	logic [5:0]             time_second;

	modport source (
		output valid, select_line, clock_line, direction_write, data_bit,
		output time_year, time_month, time_day, time_weekday,
		output time_hour, time_minute, time_second,
		input  ready
	);
	modport sink (
		input  valid, select_line, clock_line, direction_write, data_bit,
		input  time_year, time_month, time_day, time_weekday,
		input  time_hour, time_minute, time_second,
		output ready
	);
endinterface

interface rtcsci_rsp_if;
	logic valid;
	logic ready;
	logic data_bit_out;

	modport source (output valid, data_bit_out, input ready);
	modport sink (input valid, data_bit_out, output ready);
endinterface

// File: rtl/rtc_serial_command_interface.sv
// rtc three-wire serial port driven by bit-banged port register writes
// depends on rtcsci_pkg, rtcsci_if.sv and rtcsci_read_mux
//
// usage:
//   cmd channel: one request per port register write, carrying select,
//   clock, direction and data levels plus the current calendar time
//   rsp channel: one request per cmd request, carrying the data level
//   readable back from the port
// path: an accepted cmd request is registered in the input register, then
//   processed and placed in the result register, which raises rsp valid
// throughput: one request per cycle while rsp is taken; the edge detect, bit counter and read
//   byte select all sit in one stage between the input and result register
// stall: while rsp is not taken the result register holds, the input
//   register fills, then cmd ready drops; nothing is lost
// reset: clears the serial state (previous levels, bit counter, command,
//   both status registers) and empties both registers
module rtc_serial_command_interface (
	input  logic         clk,
	input  logic         arst_n,
	rtcsci_cmd_if.sink   cmd,
	rtcsci_rsp_if.source rsp
);

	// input register
	logic                  valid_s1;
	logic                  select_s1;
	logic                  clock_s1;
	logic                  dir_s1;
	logic                  data_s1;
	rtcsci_pkg::calendar_t cal_s1;

	// serial state
	logic       prev_select_q;
	logic       prev_clock_q;
	logic       prev_data_q;
	logic [6:0] bit_count_q;
	logic [7:0] command_q;
	logic [7:0] status_one_q;
	logic [7:0] status_two_q;

	// result register
	logic rsp_valid_q;
	logic data_out_q;

	logic                  advance;
	logic                  held;
	logic                  shift;
	logic [2:0]            pos;
	logic                  in_cmd;
	logic [7:0]            rd_byte;
	logic                  level;
	rtcsci_pkg::read_ctl_t rd_ctl;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;

	assign held   = prev_select_q && select_s1;
	assign shift  = held && prev_clock_q && !clock_s1;
	assign pos    = bit_count_q[2:0];
	assign in_cmd = bit_count_q < 7'(rtcsci_pkg::CMD_BITS);

	assign rd_ctl.sel     = command_q[6:4];
	assign rd_ctl.byte_no = bit_count_q[6:3];
	assign rd_ctl.hour_24 = status_one_q[rtcsci_pkg::HOUR_MODE_BIT];

	rtcsci_read_mux u_read_mux (
		.ctl        (rd_ctl),
		.cal        (cal_s1),
		.status_one (status_one_q),
		.status_two (status_two_q),
		.rd_byte    (rd_byte)
	);

	always_comb begin
		level = data_s1;
		if (held) begin
			if (shift) begin
				if (!in_cmd && !dir_s1) begin
					level = rd_byte[pos];
				end
			end else if (!dir_s1) begin
				level = prev_data_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			select_s1      <= cmd.select_line;
			clock_s1       <= cmd.clock_line;
			dir_s1         <= cmd.direction_write;
			data_s1        <= cmd.data_bit;
			cal_s1.year    <= cmd.time_year;
			cal_s1.month   <= cmd.time_month;
			cal_s1.day     <= cmd.time_day;
			cal_s1.weekday <= cmd.time_weekday;
			cal_s1.hour    <= cmd.time_hour;
			cal_s1.minute  <= cmd.time_minute;
			cal_s1.second  <= cmd.time_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_select_q <= 1'b0;
			prev_clock_q  <= 1'b0;
			prev_data_q   <= 1'b0;
			bit_count_q   <= '0;
			command_q     <= '0;
			status_one_q  <= '0;
			status_two_q  <= '0;
		end else if (advance) begin
			prev_select_q <= select_s1;
			prev_clock_q  <= clock_s1;
			prev_data_q   <= level;
			if (!held) begin
				bit_count_q <= '0;
				command_q   <= '0;
			end else if (shift) begin
				if (in_cmd) begin
					command_q[pos] <= command_q[pos] | data_s1;
				end else if (dir_s1) begin
					if (command_q[6:4] == rtcsci_pkg::SEL_STATUS_ONE) begin
						status_one_q[pos] <= data_s1;
					end else if (command_q[6:4] == rtcsci_pkg::SEL_STATUS_TWO) begin
						status_two_q[pos] <= data_s1;
					end
				end
				// counter stops at the limit; later bits reuse position 0
				if (bit_count_q < rtcsci_pkg::BIT_COUNT_MAX) begin
					bit_count_q <= bit_count_q + 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_out_q <= level;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.data_bit_out = data_out_q;

`ifndef SYNTHESIS
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= rtcsci_pkg::BIT_COUNT_MAX)
		else $error("bit counter above its limit");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !held |=> bit_count_q == 7'd0 && command_q == 8'h00)
		else $error("select release did not clear the serial state");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> valid_s1 && rsp_valid_q && !rsp.ready)
		else $error("input stalled without a blocked result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("processed request produced no result");
`endif

endmodule

// File: rtl/rtcsci_read_mux.sv
// readable byte selection: status registers, bcd date-time and bcd time
// depends on rtcsci_pkg
module rtcsci_read_mux (
	input  rtcsci_pkg::read_ctl_t ctl,
	input  rtcsci_pkg::calendar_t cal,
	input  logic [7:0]            status_one,
	input  logic [7:0]            status_two,
	output logic [7:0]            rd_byte
);

	logic [7:0] hour_bcd;
	logic [7:0] dt_byte;
	logic [7:0] tm_byte;
	logic [3:0] tm_idx;

	always_comb begin
		if (ctl.hour_24) begin
			hour_bcd = rtcsci_pkg::to_bcd({2'b00, cal.hour});
		end else begin
			hour_bcd = rtcsci_pkg::to_bcd({2'b00, rtcsci_pkg::hour_mod12(cal.hour)});
		end
	end

	// byte 0 is the command, so data bytes start at one
	always_comb begin
		case (ctl.byte_no)
			4'd1:    dt_byte = rtcsci_pkg::to_bcd(cal.year);
			4'd2:    dt_byte = rtcsci_pkg::to_bcd({3'b000, cal.month});
			4'd3:    dt_byte = rtcsci_pkg::to_bcd({2'b00, cal.day});
			4'd4:    dt_byte = rtcsci_pkg::to_bcd({4'b0000, cal.weekday});
			4'd5:    dt_byte = hour_bcd;
			4'd6:    dt_byte = rtcsci_pkg::to_bcd({1'b0, cal.minute});
			4'd7:    dt_byte = rtcsci_pkg::to_bcd({1'b0, cal.second});
			default: dt_byte = 8'h00;
		endcase
	end

	// time read wraps hour, minute, second
	assign tm_idx = ctl.byte_no;
	always_comb begin
		case (tm_idx)
			4'd1, 4'd4, 4'd7: tm_byte = hour_bcd;
			4'd2, 4'd5, 4'd8: tm_byte = rtcsci_pkg::to_bcd({1'b0, cal.minute});
			4'd3, 4'd6:       tm_byte = rtcsci_pkg::to_bcd({1'b0, cal.second});
			default:          tm_byte = 8'h00;
		endcase
	end

	always_comb begin
		case (ctl.sel)
			rtcsci_pkg::SEL_STATUS_ONE: rd_byte = status_one;
			rtcsci_pkg::SEL_STATUS_TWO: rd_byte = status_two;
			rtcsci_pkg::SEL_DATETIME:   rd_byte = dt_byte;
			rtcsci_pkg::SEL_TIME:       rd_byte = tm_byte;
			default:                    rd_byte = 8'h00;
		endcase
	end

endmodule
